FILE: hdl/pbt_pkg.sv
// Shared types, constants and helpers for the price ladder best price tracker.
// No dependencies; the interfaces, engine and top level import this package.
package pbt_pkg;

	// ladder geometry
	localparam int NUM_LEVELS = 1024;
	localparam int LVL_W      = $clog2(NUM_LEVELS);
	localparam int CNT_W      = $clog2(NUM_LEVELS + 1);
	localparam int VOL_W      = 32;
	localparam int PRICE_W    = 32;
	localparam int SUM_W      = VOL_W + 1;
	localparam logic [LVL_W-1:0] LAST_IDX = LVL_W'(NUM_LEVELS - 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOK_SIDE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_PRICE = 1'b1;

	// book side codes
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	// operation codes; 5 to 7 are unused and fall to default arms
	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_SET   = 3'd1,
		OP_SCAN  = 3'd2,
		OP_LIQ   = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_ACCESS,
		ST_SCAN,
		ST_LIQ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               book_side;
		logic [PRICE_W-1:0] lowest_price;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [PRICE_W-1:0] price;
		logic [VOL_W-1:0]   quantity;
	} req_t;

	typedef struct packed {
		logic               answer;
		logic               best_valid;
		logic [PRICE_W-1:0] best_price;
		logic [CNT_W-1:0]   nonempty_count;
		logic               error;
	} result_t;

	typedef struct packed {
		logic             we;
		logic [LVL_W-1:0] waddr;
		logic [VOL_W-1:0] wdata;
		logic             re;
		logic [LVL_W-1:0] raddr;
	} ram_req_t;

	// one level toward the scan direction, holding at the ladder end
	function automatic logic [LVL_W-1:0] step_idx(input logic [LVL_W-1:0] cur,
	                                              input logic side);
		logic [LVL_W-1:0] nxt;
		nxt = cur;
		if (side == SIDE_BUY) begin
			if (cur != '0) nxt = cur - 1'b1;
		end else begin
			if (cur != LAST_IDX) nxt = cur + 1'b1;
		end
		return nxt;
	endfunction

endpackage

FILE: hdl/pbt_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on pbt_pkg for field widths.
interface pbt_in_if;
	import pbt_pkg::*;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [PRICE_W-1:0] price;
	logic [VOL_W-1:0]   quantity;

	modport source (output valid, output opcode, output price, output quantity, input ready);
	modport sink (input valid, input opcode, input price, input quantity, output ready);
endinterface

interface pbt_out_if;
	import pbt_pkg::*;
	logic               valid;
	logic               ready;
	logic               answer;
	logic               best_valid;
	logic [PRICE_W-1:0] best_price;
	logic [CNT_W-1:0]   nonempty_count;
	logic               error;

	modport source (output valid, output answer, output best_valid, output best_price,
		output nonempty_count, output error, input ready);
	modport sink (input valid, input answer, input best_valid, input best_price,
		input nonempty_count, input error, output ready);
endinterface

FILE: hdl/pbt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module pbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

FILE: hdl/pbt_engine.sv
// Sequencer and datapath: clearing pass, level read-modify-write, rescan and
// liquidity walk over the level memory. Depends on pbt_pkg.
module pbt_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pbt_pkg::cfg_t          cfg,
	input  logic                   start,
	input  pbt_pkg::req_t          req,
	output logic                   idle,
	output logic                   done,
	input  logic                   taken,
	output pbt_pkg::result_t       result,
	output pbt_pkg::ram_req_t      ram,
	input  logic [pbt_pkg::VOL_W-1:0] rdata
);
	import pbt_pkg::*;

	state_t state_q, state_d;

	logic [2:0]       op_q;
	logic [LVL_W-1:0] idx_q;
	logic [VOL_W-1:0] qty_q;
	logic             inside_q;
	logic [LVL_W-1:0] cur_q;
	logic [LVL_W-1:0] addr_s1;
	logic             rdv_s1;
	logic [SUM_W-1:0] sum_q;
	logic [LVL_W-1:0] best_idx_q;
	logic             best_pres_q;
	logic [CNT_W-1:0] occ_q;
	logic             answer_q;
	logic             error_q;

	logic [PRICE_W-1:0] diff;
	logic               in_range;
	logic [LVL_W-1:0]   scan_end;
	logic               vol_nz;
	logic [SUM_W:0]     sum_next;
	logic               liq_hit;
	logic               liq_skip;

	// ladder range check on the incoming price
	assign diff     = req.price - cfg.lowest_price;
	assign in_range = (req.price >= cfg.lowest_price) && (diff < PRICE_W'(NUM_LEVELS));

	assign scan_end = (cfg.book_side == SIDE_BUY) ? '0 : LAST_IDX;
	assign vol_nz   = (rdata != '0);
	assign sum_next = {1'b0, sum_q} + (SUM_W + 1)'(rdata);
	assign liq_hit  = vol_nz && (sum_next >= (SUM_W + 1)'(qty_q));

	// liquidity check that ends before any walk
	always_comb begin
		liq_skip = (qty_q == '0) || !best_pres_q;
		if (cfg.book_side == SIDE_BUY) begin
			if (best_idx_q < idx_q) liq_skip = 1'b1;
		end else begin
			if (best_idx_q > idx_q) liq_skip = 1'b1;
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);

	// result fields
	always_comb begin
		result.answer         = answer_q;
		result.best_valid     = best_pres_q;
		result.best_price     = best_pres_q ?
			(cfg.lowest_price + PRICE_W'(best_idx_q)) : '0;
		result.nonempty_count = occ_q;
		result.error          = error_q;
	end

	// next state and memory requests
	always_comb begin
		state_d   = state_q;
		ram.we    = 1'b0;
		ram.waddr = idx_q;
		ram.wdata = qty_q;
		ram.re    = 1'b0;
		ram.raddr = cur_q;
		case (state_q)
			ST_CLEAR: begin
				ram.we    = 1'b1;
				ram.waddr = cur_q;
				ram.wdata = '0;
				if (cur_q == LAST_IDX) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_d = ST_DONE;
				if (inside_q) begin
					case (op_q)
						OP_WRITE, OP_QUERY: begin
							ram.re    = 1'b1;
							ram.raddr = idx_q;
							state_d   = ST_ACCESS;
						end
						OP_SCAN: begin
							ram.re    = 1'b1;
							ram.raddr = idx_q;
							state_d   = ST_SCAN;
						end
						OP_LIQ: begin
							if (!liq_skip) begin
								ram.re    = 1'b1;
								ram.raddr = best_idx_q;
								state_d   = ST_LIQ;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_ACCESS: begin
				ram.we  = (op_q == OP_WRITE);
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				ram.re = 1'b1;
				if (vol_nz || addr_s1 == scan_end) state_d = ST_DONE;
			end
			ST_LIQ: begin
				ram.re = 1'b1;
				if (liq_hit || addr_s1 == idx_q) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (taken) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// read pipeline tag: address and valid of the data on rdata
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= ram.re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram.re) addr_s1 <= ram.raddr;
	end

	// control state: ladder bookkeeping, walk pointer and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			best_idx_q  <= '0;
			best_pres_q <= 1'b0;
			occ_q       <= '0;
			answer_q    <= 1'b0;
			error_q     <= 1'b0;
			inside_q    <= 1'b0;
			op_q        <= OP_WRITE;
			sum_q       <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cur_q <= cur_q + 1'b1;
				end
				ST_IDLE: begin
					if (start) begin
						op_q     <= req.opcode;
						inside_q <= in_range;
						answer_q <= 1'b0;
						error_q  <= 1'b0;
					end
				end
				ST_DISPATCH: begin
					sum_q <= '0;
					case (op_q)
						OP_WRITE, OP_QUERY: begin
							if (!inside_q) error_q <= 1'b1;
						end
						OP_SET: begin
							if (!inside_q) begin
								error_q <= 1'b1;
							end else begin
								best_idx_q  <= idx_q;
								best_pres_q <= 1'b1;
							end
						end
						OP_SCAN: begin
							if (!inside_q) error_q <= 1'b1;
							cur_q <= step_idx(idx_q, cfg.book_side);
						end
						OP_LIQ: begin
							if (!inside_q || qty_q == '0) error_q <= 1'b1;
							cur_q <= step_idx(best_idx_q, cfg.book_side);
						end
						default: ;
					endcase
				end
				ST_ACCESS: begin
					if (op_q == OP_WRITE) begin
						if (!vol_nz && qty_q != '0) occ_q <= occ_q + 1'b1;
						else if (vol_nz && qty_q == '0) occ_q <= occ_q - 1'b1;
					end else begin
						answer_q <= vol_nz;
					end
				end
				ST_SCAN: begin
					cur_q <= step_idx(cur_q, cfg.book_side);
					if (vol_nz) begin
						best_idx_q  <= addr_s1;
						best_pres_q <= 1'b1;
					end else if (addr_s1 == scan_end) begin
						best_pres_q <= 1'b0;
					end
				end
				ST_LIQ: begin
					cur_q <= step_idx(cur_q, cfg.book_side);
					if (liq_hit) answer_q <= 1'b1;
					sum_q <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// item payload, captured at acceptance
	always_ff @(posedge clk) begin
		if (start && idle) begin
			idx_q <= diff[LVL_W-1:0];
			qty_q <= req.quantity;
		end
	end

	// the level store is never written while walking it
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_LIQ) |-> !ram.we)
		else $error("level store written during a walk");

	// every walk or access cycle has read data from the previous cycle
	a_walk_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_LIQ || state_q == ST_ACCESS) |-> rdv_s1)
		else $error("walk step without read data");

	// occupancy never exceeds the ladder size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(NUM_LEVELS))
		else $error("occupied level count out of range");

	// a finished result waits until the output stage takes it
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !taken) |=> (state_q == ST_DONE))
		else $error("result dropped before it was taken");

endmodule

FILE: hdl/price_ladder_best_price_tracker.sv
// Top level of the price ladder best price tracker: configuration registers,
// level memory, sequencer and output register. Depends on pbt_pkg, pbt_if,
// pbt_ram and pbt_engine.
//
// Usage:
//  - req carries one item (opcode, price, quantity); rsp returns exactly one
//    result item per request, in order. Both are valid/ready channels.
//  - cfg_we/cfg_index/cfg_data write book_side (index 0) and lowest_price
//    (index 1); write them only while no item is in flight.
//  - After reset the level memory is cleared, one level per cycle, over all
//    NUM_LEVELS (1024) levels; req.ready stays low during that pass.
//  - One item is worked on at a time. From acceptance the sequencer goes
//    through a dispatch state and then, for set best, unused opcodes, errors
//    and liquidity checks that need no walk, straight to the done state; write
//    volume and level query first do one read-modify-write of the level
//    memory, and rescan and liquidity check first walk up to NUM_LEVELS
//    levels, one memory read a cycle. The result then lands in the output
//    register, and the next item is accepted the cycle after that.
//  - If rsp stalls, the result sits in the output register; the block still
//    takes and works on one more item and then holds its result until the
//    output register is free.
module price_ladder_best_price_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbt_pkg::CFG_DATA_W-1:0] cfg_data,
	pbt_in_if.sink                         req,
	pbt_out_if.source                      rsp
);
	import pbt_pkg::*;

	cfg_t             cfg_q;
	req_t             req_item;
	result_t          result;
	result_t          out_q;
	logic             out_valid_q;
	ram_req_t         ram;
	logic [VOL_W-1:0] rdata;
	logic             idle;
	logic             done;
	logic             out_load;
	logic             start;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOOK_SIDE:    cfg_q.book_side    <= cfg_data[0];
				CFG_LOWEST_PRICE: cfg_q.lowest_price <= cfg_data[PRICE_W-1:0];
				default: ;
			endcase
		end
	end

	// input side
	assign req.ready         = idle;
	assign start             = req.valid && idle;
	assign req_item.opcode   = req.opcode;
	assign req_item.price    = req.price;
	assign req_item.quantity = req.quantity;

	pbt_ram #(
		.WIDTH (VOL_W),
		.DEPTH (NUM_LEVELS)
	) u_levels (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	pbt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (start),
		.req    (req_item),
		.idle   (idle),
		.done   (done),
		.taken  (out_load),
		.result (result),
		.ram    (ram),
		.rdata  (rdata)
	);

	// output register between the engine and the result channel
	assign out_load = done && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= result;
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.answer         = out_q.answer;
	assign rsp.best_valid     = out_q.best_valid;
	assign rsp.best_price     = out_q.best_price;
	assign rsp.nonempty_count = out_q.nonempty_count;
	assign rsp.error          = out_q.error;

endmodule
